[sv/rrw_pkg.sv]
// rrw_pkg: shared types, codes and constants of the receive reorder window
// used by rrw_slot_ram, rrw_ctrl and receive_reorder_window; no dependencies
`timescale 1ns / 1ps

package rrw_pkg;

   // default sizing, used as the defaults of the top level parameters
   localparam int WINDOW_SLOTS_DEF = 64;
   localparam int MAX_PAYLOAD_DEF  = 1024;

   // headers in front of the payload (ip plus icmp plus tunnel header)
   localparam int HDR_BYTES = 56;

   // fixed field widths
   localparam int SEQ_W    = 16;
   localparam int LEN_W    = 11;
   localparam int TLEN_W   = 16;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int HELD_W   = 7;

   // request kinds
   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STS_IN_ORDER   = 3'd0,
      STS_OUT_ORDER  = 3'd1,
      STS_SLOT_BUSY  = 3'd2,
      STS_OUT_WINDOW = 3'd3,
      STS_HELD       = 3'd4,
      STS_SHORT      = 3'd5,
      STS_RELEASED   = 3'd6,
      STS_NOTHING    = 3'd7
   } status_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_DECODE = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_WALK   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      OP_RELEASE  = 2'd0,
      OP_IN_ORDER = 2'd1,
      OP_AHEAD    = 2'd2
   } op_type;

   // one window slot as kept in the slot memory
   typedef struct packed {
      logic             full;
      logic [SEQ_W-1:0] seq;
      logic [LEN_W-1:0] len;
   } slot_entry_type;

   // one result, as handed from the sequencer to the output register
   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [SEQ_W-1:0]  out_seq;
      logic [LEN_W-1:0]  out_len;
      logic [SEQ_W-1:0]  next_expected;
      logic [HELD_W-1:0] held_count;
   } result_type;

endpackage

[sv/receive_reorder_window.sv]
// receive_reorder_window: top level of the sliding receive reorder window
// depends on rrw_pkg, rrw_slot_ram and rrw_ctrl
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tuser: req_type, tdata: seq_no, payload_len, rx_len
// rsp_      out  rsp_tvalid/rsp_tready  tuser: status, tdata: slot .. held_count
//
// flow: one request at a time; a short or out of window arrival goes from ST_DECODE
//   straight to ST_DONE, a release or an out of order arrival passes ST_CHECK, and
//   an in order arrival then also runs the skip walk in ST_WALK over the following
//   held slots (one slot memory read per cycle)
// reset: synchronous; afterwards a clearing pass writes every slot of the slot
//   memory empty and req_tready stays low until it ends
// stalls: the result sits in an output register; while it waits for rsp_tready
//   a finished request holds the sequencer and no new request is taken

module receive_reorder_window #(
   parameter int WINDOW_SLOTS = rrw_pkg::WINDOW_SLOTS_DEF,
   parameter int MAX_PAYLOAD  = rrw_pkg::MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] req_type
   input  logic [47:0] req_tdata,   // [15:0] seq_no, [26:16] payload_len, [42:27] rx_len
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic [55:0] rsp_tdata    // [5:0] slot, [21:6] out_seq, [32:22] out_len,
                                    // [48:33] next_expected, [55:49] held_count
);

   localparam int IDX_W = $clog2(WINDOW_SLOTS);

   logic                    req_fire;
   logic                    rsp_free;
   logic                    done_valid;
   logic                    rsp_load;
   rrw_pkg::result_type     result;

   // slot memory ports
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   rrw_pkg::slot_entry_type wr_data;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   rrw_pkg::slot_entry_type rd_data;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   rrw_pkg::result_type     rsp_data_ff, rsp_data_in;

   assign req_fire = req_tvalid && req_tready;
   // output register can take a result when empty or being drained
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = done_valid && rsp_free;

   rrw_ctrl #(
      .WINDOW_SLOTS (WINDOW_SLOTS),
      .MAX_PAYLOAD  (MAX_PAYLOAD)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_ready  (req_tready),
      .req_kind   (req_tuser[0]),
      .req_seq    (req_tdata[15:0]),
      .req_len    (req_tdata[26:16]),
      .req_tlen   (req_tdata[42:27]),
      .done_valid (done_valid),
      .rsp_free   (rsp_free),
      .result     (result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   rrw_slot_ram #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register, loaded when the sequencer finishes a request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {rsp_data_ff.held_count,
                        rsp_data_ff.next_expected,
                        rsp_data_ff.out_len,
                        rsp_data_ff.out_seq,
                        rsp_data_ff.slot};

   // the sequencer is busy straight after taking a request
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
   else $error("request taken while previous one in progress");

   // a finished result and an open request port never coexist
   a_done_not_ready : assert property (@(posedge clock) disable iff (reset)
      !(done_valid && req_tready))
   else $error("result pending while taking requests");

   // dropped and empty cases report slot zero and no released data
   a_drop_slot_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (result.status == rrw_pkg::STS_SHORT ||
                    result.status == rrw_pkg::STS_OUT_WINDOW ||
                    result.status == rrw_pkg::STS_NOTHING))
      |-> (result.slot == '0 && result.out_seq == '0 && result.out_len == '0))
   else $error("dropped request reports a slot or data");

   // a loaded result shows on the channel in the next cycle
   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_tvalid && rsp_tuser == $past(result.status)))
   else $error("result register not loaded");

endmodule

[sv/rrw_slot_ram.sv]
// rrw_slot_ram: slot memory of the reorder window, one write and one read port
// depends on rrw_pkg for the slot entry type
`timescale 1ns / 1ps

module rrw_slot_ram #(
   parameter int WINDOW_SLOTS = rrw_pkg::WINDOW_SLOTS_DEF,
   localparam int IDX_W = $clog2(WINDOW_SLOTS)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  rrw_pkg::slot_entry_type wr_data,
   input  logic                    rd_en,
   input  logic [IDX_W-1:0]        rd_addr,
   output rrw_pkg::slot_entry_type rd_data
);

   rrw_pkg::slot_entry_type mem [WINDOW_SLOTS];
   rrw_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rrw_ctrl.sv]
// rrw_ctrl: sequencer of the reorder window, window state and the skip walk
// depends on rrw_pkg; drives the ports of rrw_slot_ram
`timescale 1ns / 1ps

module rrw_ctrl #(
   parameter int WINDOW_SLOTS = rrw_pkg::WINDOW_SLOTS_DEF,
   parameter int MAX_PAYLOAD  = rrw_pkg::MAX_PAYLOAD_DEF,
   localparam int IDX_W = $clog2(WINDOW_SLOTS),
   localparam int CNT_W = $clog2(WINDOW_SLOTS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   // request side
   input  logic                        req_fire,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [rrw_pkg::SEQ_W-1:0]   req_seq,
   input  logic [rrw_pkg::LEN_W-1:0]   req_len,
   input  logic [rrw_pkg::TLEN_W-1:0]  req_tlen,
   // result side
   output logic                        done_valid,
   input  logic                        rsp_free,
   output rrw_pkg::result_type         result,
   // slot memory
   output logic                        wr_en,
   output logic [IDX_W-1:0]            wr_addr,
   output rrw_pkg::slot_entry_type     wr_data,
   output logic                        rd_en,
   output logic [IDX_W-1:0]            rd_addr,
   input  rrw_pkg::slot_entry_type     rd_data
);

   rrw_pkg::state_type  state_ff, state_in;
   rrw_pkg::op_type     op_ff, op_in;
   rrw_pkg::status_type status_ff, status_in;

   logic                       kind_ff, kind_in;
   logic [rrw_pkg::SEQ_W-1:0]  seq_ff, seq_in;
   logic [rrw_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [rrw_pkg::TLEN_W-1:0] tlen_ff, tlen_in;

   logic [rrw_pkg::SEQ_W-1:0]  expected_ff, expected_in;
   logic [IDX_W-1:0]           insert_ff, insert_in;
   logic [IDX_W-1:0]           release_ff, release_in;
   logic [CNT_W-1:0]           held_ff, held_in;
   logic [IDX_W-1:0]           addr_ff, addr_in;
   logic [CNT_W-1:0]           steps_ff, steps_in;
   logic [IDX_W-1:0]           clr_ff, clr_in;
   logic [rrw_pkg::SEQ_W-1:0]  oseq_ff, oseq_in;
   logic [rrw_pkg::LEN_W-1:0]  olen_ff, olen_in;

   // shared arithmetic
   logic [16:0]               need_raw;
   logic [16:0]               need_even;
   logic                      is_short;
   logic [rrw_pkg::SEQ_W-1:0] seq_gap;
   logic                      out_window;
   logic [IDX_W:0]            pos_sum;
   logic [IDX_W-1:0]          pos;
   logic [IDX_W-1:0]          insert_next;
   logic [15:0]               slot_wide;
   logic [15:0]               held_wide;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
      logic [IDX_W-1:0] r;
      if (s == IDX_W'(WINDOW_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

   // length check: payload over MAX_PAYLOAD, or rx length under headers plus payload rounded up to even
   assign need_raw  = 17'(rrw_pkg::HDR_BYTES) + {6'd0, len_ff};
   assign need_even = need_raw + {16'd0, need_raw[0]};
   assign is_short  = ({6'd0, len_ff} > 17'(MAX_PAYLOAD)) || ({1'b0, tlen_ff} < need_even);

   // distance ahead of the expected number and its slot
   assign seq_gap    = seq_ff - expected_ff;
   assign out_window = {1'b0, seq_gap} >= 17'(WINDOW_SLOTS);
   assign pos_sum    = {1'b0, insert_ff} + {1'b0, seq_gap[IDX_W-1:0]};
   assign pos        = (pos_sum >= (IDX_W+1)'(WINDOW_SLOTS)) ?
                       IDX_W'(pos_sum - (IDX_W+1)'(WINDOW_SLOTS)) : pos_sum[IDX_W-1:0];

   assign insert_next = next_slot(insert_ff);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      kind_in     = kind_ff;
      seq_in      = seq_ff;
      len_in      = len_ff;
      tlen_in     = tlen_ff;
      expected_in = expected_ff;
      insert_in   = insert_ff;
      release_in  = release_ff;
      held_in     = held_ff;
      addr_in     = addr_ff;
      steps_in    = steps_ff;
      clr_in      = clr_ff;
      oseq_in     = oseq_ff;
      olen_in     = olen_ff;
      req_ready   = 1'b0;
      done_valid  = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = addr_ff;

      case (state_ff)
         rrw_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == IDX_W'(WINDOW_SLOTS - 1)) begin
               state_in = rrw_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         rrw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               kind_in  = req_kind;
               seq_in   = req_seq;
               len_in   = req_len;
               tlen_in  = req_tlen;
               state_in = rrw_pkg::ST_DECODE;
            end
         end

         rrw_pkg::ST_DECODE: begin
            oseq_in = '0;
            olen_in = '0;
            if (kind_ff == rrw_pkg::REQ_RELEASE) begin
               op_in    = rrw_pkg::OP_RELEASE;
               addr_in  = release_ff;
               rd_en    = 1'b1;
               rd_addr  = release_ff;
               state_in = rrw_pkg::ST_CHECK;
            end else if (is_short) begin
               status_in = rrw_pkg::STS_SHORT;
               addr_in   = '0;
               state_in  = rrw_pkg::ST_DONE;
            end else if (seq_ff == expected_ff) begin
               op_in    = rrw_pkg::OP_IN_ORDER;
               addr_in  = insert_ff;
               rd_en    = 1'b1;
               rd_addr  = insert_ff;
               state_in = rrw_pkg::ST_CHECK;
            end else if (out_window) begin
               status_in = rrw_pkg::STS_OUT_WINDOW;
               addr_in   = '0;
               state_in  = rrw_pkg::ST_DONE;
            end else begin
               op_in    = rrw_pkg::OP_AHEAD;
               addr_in  = pos;
               rd_en    = 1'b1;
               rd_addr  = pos;
               state_in = rrw_pkg::ST_CHECK;
            end
         end

         rrw_pkg::ST_CHECK: begin
            case (op_ff)
               rrw_pkg::OP_RELEASE: begin
                  state_in = rrw_pkg::ST_DONE;
                  if (!rd_data.full) begin
                     status_in = rrw_pkg::STS_NOTHING;
                     addr_in   = '0;
                  end else begin
                     wr_en      = 1'b1;
                     status_in  = rrw_pkg::STS_RELEASED;
                     oseq_in    = rd_data.seq;
                     olen_in    = rd_data.len;
                     release_in = next_slot(addr_ff);
                     if (held_ff != '0) begin
                        held_in = held_ff - 1'b1;
                     end
                  end
               end

               rrw_pkg::OP_AHEAD: begin
                  state_in = rrw_pkg::ST_DONE;
                  if (rd_data.full) begin
                     status_in = rrw_pkg::STS_HELD;
                  end else begin
                     wr_en     = 1'b1;
                     wr_data   = '{full: 1'b1, seq: seq_ff, len: len_ff};
                     held_in   = held_ff + 1'b1;
                     status_in = rrw_pkg::STS_OUT_ORDER;
                  end
               end

               default: begin
                  // in order: store if free, then start the skip walk
                  expected_in = expected_ff + 1'b1;
                  steps_in    = '0;
                  rd_en       = 1'b1;
                  state_in    = rrw_pkg::ST_WALK;
                  if (rd_data.full) begin
                     status_in = rrw_pkg::STS_SLOT_BUSY;
                     rd_addr   = insert_ff;
                  end else begin
                     wr_en     = 1'b1;
                     wr_data   = '{full: 1'b1, seq: seq_ff, len: len_ff};
                     held_in   = held_ff + 1'b1;
                     insert_in = insert_next;
                     status_in = rrw_pkg::STS_IN_ORDER;
                     rd_addr   = insert_next;
                  end
               end
            endcase
         end

         rrw_pkg::ST_WALK: begin
            // rd_data holds the slot at insert_ff
            if (rd_data.full && (rd_data.seq == expected_ff) &&
                (steps_ff != CNT_W'(WINDOW_SLOTS))) begin
               expected_in = expected_ff + 1'b1;
               insert_in   = insert_next;
               steps_in    = steps_ff + 1'b1;
               rd_en       = 1'b1;
               rd_addr     = insert_next;
            end else begin
               state_in = rrw_pkg::ST_DONE;
            end
         end

         rrw_pkg::ST_DONE: begin
            done_valid = 1'b1;
            if (rsp_free) begin
               state_in = rrw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rrw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rrw_pkg::ST_CLEAR;
         expected_ff <= '0;
         insert_ff   <= '0;
         release_ff  <= '0;
         held_ff     <= '0;
         clr_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         expected_ff <= expected_in;
         insert_ff   <= insert_in;
         release_ff  <= release_in;
         held_ff     <= held_in;
         clr_ff      <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      kind_ff   <= kind_in;
      seq_ff    <= seq_in;
      len_ff    <= len_in;
      tlen_ff   <= tlen_in;
      addr_ff   <= addr_in;
      steps_ff  <= steps_in;
      oseq_ff   <= oseq_in;
      olen_ff   <= olen_in;
   end

   assign slot_wide = 16'(addr_ff);
   assign held_wide = 16'(held_ff);

   assign result = '{
      status:        status_ff,
      slot:          slot_wide[rrw_pkg::SLOT_W-1:0],
      out_seq:       oseq_ff,
      out_len:       olen_ff,
      next_expected: expected_ff,
      held_count:    held_wide[rrw_pkg::HELD_W-1:0]
   };

endmodule
